// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the color converter.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/hsl_pkg.sv =====
// Shared types and stage numbering for the HSL to RGB converter pipeline.
// No dependencies.
`timescale 1ns / 1ps

package hsl_pkg;

  // Pipeline stages: A clamp and L*S, B m1/m2 and ramp decode,
  // C ramp product, D channel level, E scale to 8 bits.
  localparam int NUM_STAGES = 5;
  localparam int STG_A = 0;
  localparam int STG_B = 1;
  localparam int STG_C = 2;
  localparam int STG_D = 3;
  localparam int STG_E = 4;

  // Hue ramp segment.
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

// ===== rtl/core/hsl_levels.sv =====
// Lightness/saturation path: clamps inputs, forms L*S, then m1, m2 and m2-m1.
// Depends on hsl_pkg.
`timescale 1ns / 1ps

module hsl_levels #(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  hsl_pkg::pipe_ctl_t    ctl,
  input  logic [FRAC_BITS:0]    lightness,
  input  logic [FRAC_BITS:0]    saturation,
  output logic [FRAC_BITS:0]    diff_b,
  output logic [FRAC_BITS:0]    m1_c,
  output logic [FRAC_BITS:0]    m2_c
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] HALF = ONE >> 1;

  logic [W-1:0]   l_clamp, s_clamp;
  logic [2*W-1:0] ls_full;
  logic [W-1:0]   l_a, s_a, ls_a;
  logic [W-1:0]   s_minus_ls;
  logic [W:0]     m2_w, m1_w, diff_w;
  logic [W-1:0]   m1_b, m2_b;

  // Stage A: clamp to 1.0 and truncated product
  always_comb begin
    l_clamp = (lightness > ONE) ? ONE : lightness;
    s_clamp = (saturation > ONE) ? ONE : saturation;
    ls_full = l_clamp * s_clamp;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_A]) begin
      l_a  <= l_clamp;
      s_a  <= s_clamp;
      ls_a <= ls_full[FRAC_BITS +: W];
    end
  end

  // Stage B: m2 = L+LS or L+S-LS, m1 = 2L-m2, all within [0, 1.0]
  always_comb begin
    s_minus_ls = s_a - ls_a;
    if (l_a <= HALF) begin
      m2_w   = {1'b0, l_a} + {1'b0, ls_a};
      diff_w = {ls_a, 1'b0};
    end else begin
      m2_w   = {1'b0, l_a} + {1'b0, s_a} - {1'b0, ls_a};
      diff_w = {s_minus_ls, 1'b0};
    end
    m1_w = {l_a, 1'b0} - m2_w;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_B]) begin
      m1_b   <= m1_w[W-1:0];
      m2_b   <= m2_w[W-1:0];
      diff_b <= diff_w[W-1:0];
    end
  end

  // Stage C: carry levels alongside the ramp product
  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_C]) begin
      m1_c <= m1_b;
      m2_c <= m2_b;
    end
  end

endmodule

// ===== rtl/core/hsl_channel.sv =====
// One color channel: hue ramp decode, ramp product, level select, 8-bit scale.
// Depends on hsl_pkg; m1/m2/diff come from hsl_levels.
`timescale 1ns / 1ps

module hsl_channel #(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  hsl_pkg::pipe_ctl_t    ctl,
  input  logic [FRAC_BITS-1:0]  hue_shift,
  input  logic [FRAC_BITS:0]    diff_b,
  input  logic [FRAC_BITS:0]    m1_c,
  input  logic [FRAC_BITS:0]    m2_c,
  output logic [7:0]            level
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] TWO_THIRDS =
    FRAC_BITS'((2 * (1 << FRAC_BITS)) / 3);

  logic [FRAC_BITS-1:0] h_a;
  logic [FRAC_BITS+2:0] h6, t6;
  logic [FRAC_BITS+1:0] h3;
  logic [FRAC_BITS-1:0] t;
  hsl_pkg::seg_t        seg_w, seg_b, seg_c, seg_d_unused_guard;
  logic [W-1:0]         factor_w, factor_b;
  logic [2*W-1:0]       prod_full;
  logic [W-1:0]         prod_c;
  logic [W:0]           sum_w;
  logic [W-1:0]         v_w, v_d;
  logic [W+7:0]         scaled;

  assign seg_d_unused_guard = seg_c;

  // Stage A: register the shifted hue
  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_A]) begin
      h_a <= hue_shift;
    end
  end

  // Stage B: segment decode and slope factor (6h or 6(2/3-h))
  always_comb begin
    h6 = ({3'b000, h_a} << 2) + ({3'b000, h_a} << 1);
    h3 = ({2'b00, h_a} << 1) + {2'b00, h_a};
    t  = TWO_THIRDS - h_a;
    t6 = ({3'b000, t} << 2) + ({3'b000, t} << 1);
    if (h6 < {2'b00, ONE}) begin
      seg_w    = hsl_pkg::SEG_RISE;
      factor_w = h6[W-1:0];
    end else if (!h_a[FRAC_BITS-1]) begin
      seg_w    = hsl_pkg::SEG_HIGH;
      factor_w = '0;
    end else if (h3 < {ONE, 1'b0}) begin
      seg_w    = hsl_pkg::SEG_FALL;
      factor_w = t6[W-1:0];
    end else begin
      seg_w    = hsl_pkg::SEG_LOW;
      factor_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_B]) begin
      seg_b    <= seg_w;
      factor_b <= factor_w;
    end
  end

  // Stage C: (m2-m1)*factor, truncated
  assign prod_full = diff_b * factor_b;

  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_C]) begin
      seg_c  <= seg_b;
      prod_c <= prod_full[FRAC_BITS +: W];
    end
  end

  // Stage D: channel level in [0, 1.0]
  always_comb begin
    sum_w = {1'b0, m1_c} + {1'b0, prod_c};
    case (seg_d_unused_guard)
      hsl_pkg::SEG_RISE, hsl_pkg::SEG_FALL: v_w = sum_w[W-1:0];
      hsl_pkg::SEG_HIGH:                    v_w = m2_c;
      default:                              v_w = m1_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_D]) begin
      v_d <= v_w;
    end
  end

  // Stage E: floor(v*255) as v*256 - v
  assign scaled = {v_d, 8'b0} - {8'b0, v_d};

  always_ff @(posedge clk) begin
    if (ctl.load[hsl_pkg::STG_E]) begin
      level <= scaled[FRAC_BITS +: 8];
    end
  end

endmodule

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB converter: pipeline control and hue offsets.
// Depends on hsl_pkg, hsl_levels, hsl_channel and assert_macros.svh.
`timescale 1ns / 1ps
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_stall   | hue, lightness, saturation
//  out     | out_valid / out_stall | red, green, blue
//
//  Five register stages (A..E), one item taken per cycle while in_stall is low;
//  an item moves through A, B, C, D and E in order; stage E is the output reg.
//  The stages are split around the two multipliers (L*S in A, ramp slope
//  product in C). Valid bits move with the data and a stage loads
//  when empty or draining, so in_stall rises only when all five stages are full
//  and out_stall is high. rst clears the valid bits only; data is not reset.

`include "assert_macros.svh"

module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS-1:0] hue,
  input  logic [FRAC_BITS:0]   lightness,
  input  logic [FRAC_BITS:0]   saturation,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);

  localparam int NS = hsl_pkg::NUM_STAGES;
  localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'((1 << FRAC_BITS) / 3);

  logic [NS-1:0]        vld;
  hsl_pkg::pipe_ctl_t   ctl;
  logic [FRAC_BITS-1:0] hue_r, hue_b;
  logic [FRAC_BITS:0]   diff_b, m1_c, m2_c;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    ctl.load[NS-1] = !vld[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      ctl.load[k] = !vld[k] || ctl.load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctl.load[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ctl.load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !ctl.load[0];
  assign out_valid = vld[NS-1];

  // Hue offsets by +/- one third; wrap into [0, 1) falls out of the width.
  assign hue_r = hue + THIRD;
  assign hue_b = hue - THIRD;

  hsl_levels #(.FRAC_BITS(FRAC_BITS)) u_levels (
    .clk        (clk),
    .ctl        (ctl),
    .lightness  (lightness),
    .saturation (saturation),
    .diff_b     (diff_b),
    .m1_c       (m1_c),
    .m2_c       (m2_c)
  );

  hsl_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk       (clk),
    .ctl       (ctl),
    .hue_shift (hue_r),
    .diff_b    (diff_b),
    .m1_c      (m1_c),
    .m2_c      (m2_c),
    .level     (red)
  );

  hsl_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk       (clk),
    .ctl       (ctl),
    .hue_shift (hue),
    .diff_b    (diff_b),
    .m1_c      (m1_c),
    .m2_c      (m2_c),
    .level     (green)
  );

  hsl_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk       (clk),
    .ctl       (ctl),
    .hue_shift (hue_b),
    .diff_b    (diff_b),
    .m1_c      (m1_c),
    .m2_c      (m2_c),
    .level     (blue)
  );

  // Input backpressure only when every stage is occupied.
  `ASSERT_IMPL(a_stall_full, in_stall, (&vld) && out_stall)
  // An accepted item lands in stage A.
  `ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld[0])
  // An item in stage D with an empty output stage shows up next cycle.
  `ASSERT_NEXT(a_fill_out, vld[hsl_pkg::STG_D] && !vld[hsl_pkg::STG_E], out_valid)
  // A taken result with nothing behind it leaves the output empty.
  `ASSERT_NEXT(a_drain_out, out_valid && !out_stall && !vld[hsl_pkg::STG_D], !out_valid)

endmodule
